### rtl/dichromat_color_simulation_macros.svh
// Assertion helpers used by the top-level RTL file
`ifndef DICHROMAT_COLOR_SIMULATION_MACROS_SVH
`define DICHROMAT_COLOR_SIMULATION_MACROS_SVH

// Check a consequence in the same cycle
`define DCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the next cycle
`define DCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/dcs_pkg.sv
package dcs_pkg;

  localparam int F      = 16;
  localparam int LIN_W  = F + 5;
  localparam int THR_W  = F + 6;
  localparam int LMS_W  = F + 10;
  localparam int RGB_W  = F + 12;
  localparam int COEF_W = F + 10;
  localparam int EQ_W   = 26;
  localparam int PROD_W = COEF_W + RGB_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int BIG_W  = 1024;
  localparam int NS     = 7;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_DEUTAN = 3'd1,
    MODE_PROTAN = 3'd2,
    MODE_TRITAN = 3'd3,
    MODE_GRAY   = 3'd4
  } mode_e;

  typedef logic [LIN_W-1:0]         lin_t;
  typedef logic signed [LMS_W-1:0]  lms_t;
  typedef logic signed [RGB_W-1:0]  rgb_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [EQ_W-1:0]   eq_t;
  typedef logic [THR_W-1:0]         tab_t [256];
  typedef coef_t                    coef9_t [9];
  typedef coef_t                    recon_t [24];

  localparam longint FWD_E8 [9] = '{
    5059983, 8585369, 952420,
    1893033, 8925308, 1370054,
    292202, 975732, 7145979};
  localparam longint BACK_E6 [9] = '{
    30830854, -29832659, 1610474,
    -6481468, 17715578, -2532642,
    -375690, -1199062, 14273846};
  localparam longint ANCHOR_E6 [12] = '{
    80080, 157900, 589700, 128400, 223700, 363600,
    985600, 732500, 1079, 91400, 7009, 0};
  localparam longint EQ_E8 [3] = '{
    FWD_E8[0] + FWD_E8[1] + FWD_E8[2],
    FWD_E8[3] + FWD_E8[4] + FWD_E8[5],
    FWD_E8[6] + FWD_E8[7] + FWD_E8[8]};

  function automatic logic [BIG_W-1:0] big_pow(longint y, int e);
    logic [BIG_W-1:0] a;
    a = BIG_W'(1);
    for (int k = 0; k < e; k++) a = a * BIG_W'(y);
    return a;
  endfunction

  // floor (or ceiling when up) of v^(num/den) scaled by 2^F
  function automatic longint root_q(int v, int num, int den, bit up);
    logic [BIG_W-1:0] rhs;
    logic [BIG_W-1:0] t;
    longint lo;
    longint hi;
    longint mid;
    lo  = 0;
    hi  = longint'(16) <<< F;
    rhs = big_pow(longint'(v), num) << (den * F);
    while (hi - lo > 1) begin
      mid = lo + ((hi - lo) >>> 1);
      t   = big_pow(mid, den);
      if (t <= rhs) lo = mid;
      else hi = mid;
    end
    if (up && (big_pow(lo, den) != rhs)) lo = lo + 1;
    return lo;
  endfunction

  function automatic tab_t build_tab(int num, int den, bit up);
    tab_t t;
    for (int v = 0; v < 256; v++) t[v] = THR_W'(root_q(v, num, den, up));
    return t;
  endfunction

  localparam tab_t LIN21 = build_tab(10, 21, 1'b0);
  localparam tab_t LIN20 = build_tab(1, 2, 1'b0);
  localparam tab_t THR21 = build_tab(10, 21, 1'b1);
  localparam tab_t THR20 = build_tab(1, 2, 1'b1);

  // Restoring long division for elaboration-time constants
  function automatic logic [127:0] udiv(logic [127:0] n, logic [127:0] d);
    logic [127:0] q;
    logic [127:0] r;
    q = '0;
    r = '0;
    for (int i = 127; i >= 0; i--) begin
      r = {r[126:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint scale_dec(longint n, longint den);
    longint       mag;
    logic [127:0] q;
    mag = (n < 0) ? -n : n;
    q   = udiv((128'(mag) << F) + 128'(den >>> 1), 128'(den));
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint ratio_q(longint a, longint b);
    bit           neg;
    logic [127:0] ua;
    logic [127:0] ub;
    logic [127:0] num;
    logic [127:0] q;
    logic [127:0] r;
    if (b == 0) return 0;
    neg = (a < 0) != (b < 0);
    ua  = 128'((a < 0) ? -a : a);
    ub  = 128'((b < 0) ? -b : b);
    num = ua << F;
    q   = udiv(num, ub);
    r   = num - q * ub;
    if ((r << 1) >= ub) q = q + 1;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic coef9_t build_mat(bit back);
    coef9_t m;
    for (int i = 0; i < 9; i++)
      m[i] = back ? COEF_W'(scale_dec(BACK_E6[i], 1000000))
                  : COEF_W'(scale_dec(FWD_E8[i], 100000000));
    return m;
  endfunction

  localparam coef9_t FWD_Q  = build_mat(1'b0);
  localparam coef9_t BACK_Q = build_mat(1'b1);

  // Rebuild coefficients, index mode*6 + plane*3 + cone
  function automatic recon_t build_recon();
    recon_t rc;
    longint p [3];
    int     base;
    int     miss;
    for (int k = 0; k < 24; k++) rc[k] = '0;
    for (int md = 1; md <= 3; md++) begin
      miss = (md == 1) ? 1 : ((md == 2) ? 0 : 2);
      for (int s = 0; s < 2; s++) begin
        if (md == 3) base = (s == 0) ? 9 : 3;
        else base = (s == 0) ? 6 : 0;
        p[0] = EQ_E8[1] * ANCHOR_E6[base+2] - EQ_E8[2] * ANCHOR_E6[base+1];
        p[1] = EQ_E8[2] * ANCHOR_E6[base]   - EQ_E8[0] * ANCHOR_E6[base+2];
        p[2] = EQ_E8[0] * ANCHOR_E6[base+1] - EQ_E8[1] * ANCHOR_E6[base];
        for (int j = 0; j < 3; j++)
          rc[md*6 + s*3 + j] = (j == miss) ? '0 : COEF_W'(ratio_q(-p[j], p[miss]));
      end
    end
    return rc;
  endfunction

  localparam recon_t RECON = build_recon();

endpackage

### rtl/dcs_fwd.sv
module dcs_fwd (
  input  logic                clk_i,
  input  logic [1:0]          en_i,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  output dcs_pkg::lms_t       lms_o [3],
  output logic [7:0]          gray_o
);
  import dcs_pkg::*;

  lin_t       x_q [3];
  logic [7:0] gray0_q;
  logic [7:0] gray1_q;
  lms_t       lms_q [3];
  logic [14:0] luma_sum;
  logic [28:0] luma_scaled;
  acc_t       acc [3];

  // Luma divided by 100 through a reciprocal multiply
  assign luma_sum    = 15'(30 * red_i) + 15'(59 * green_i) + 15'(11 * blue_i);
  assign luma_scaled = 29'(luma_sum) * 29'(5243);

  // Linearize each channel by table
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x_q[0]  <= LIN_W'(LIN21[red_i]);
      x_q[1]  <= LIN_W'(LIN20[green_i]);
      x_q[2]  <= LIN_W'(LIN21[blue_i]);
      gray0_q <= luma_scaled[26:19];
    end
  end

  // RGB to LMS matrix, floor back to F fraction bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = '0;
      for (int j = 0; j < 3; j++)
        acc[i] = acc[i] + ACC_W'(FWD_Q[3*i+j] * $signed({1'b0, x_q[j]}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int i = 0; i < 3; i++) lms_q[i] <= LMS_W'(acc[i] >>> F);
      gray1_q <= gray0_q;
    end
  end

  assign lms_o  = lms_q;
  assign gray_o = gray1_q;

endmodule

### rtl/dcs_rebuild.sv
module dcs_rebuild (
  input  logic           clk_i,
  input  logic [1:0]     en_i,
  input  logic [2:0]     mode_i,
  input  dcs_pkg::lms_t  lms_i [3],
  input  logic [7:0]     gray_i,
  output dcs_pkg::lms_t  lms_o [3],
  output logic [7:0]     gray_o
);
  import dcs_pkg::*;

  logic       dichro;
  logic [1:0] tn;
  logic [1:0] td;
  logic [1:0] miss;
  eq_t        eq_n;
  eq_t        eq_d;
  logic signed [LMS_W+EQ_W-1:0] lhs;
  logic signed [LMS_W+EQ_W-1:0] rhs;
  lms_t       lms2_q [3];
  logic       sel_q;
  logic [7:0] gray2_q;
  logic [7:0] gray3_q;
  lms_t       lms3_q [3];
  logic [4:0] base;
  acc_t       acc;

  assign dichro = (mode_i == MODE_DEUTAN) || (mode_i == MODE_PROTAN) ||
                  (mode_i == MODE_TRITAN);

  // Cones used by the plane test and the cone to rebuild
  always_comb begin
    case (mode_i)
      MODE_DEUTAN: begin tn = 2'd2; td = 2'd0; miss = 2'd1; end
      MODE_PROTAN: begin tn = 2'd2; td = 2'd1; miss = 2'd0; end
      MODE_TRITAN: begin tn = 2'd1; td = 2'd0; miss = 2'd2; end
      default:     begin tn = 2'd0; td = 2'd0; miss = 2'd0; end
    endcase
  end

  assign eq_n = EQ_W'(EQ_E8[tn]);
  assign eq_d = EQ_W'(EQ_E8[td]);
  assign lhs  = lms_i[tn] * eq_d;
  assign rhs  = eq_n * lms_i[td];

  // Pick the anchor plane
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      lms2_q  <= lms_i;
      sel_q   <= !(lhs < rhs);
      gray2_q <= gray_i;
    end
  end

  // Rebuild the missing cone on that plane
  assign base = dichro ? (5'(mode_i) * 5'd6 + (sel_q ? 5'd3 : 5'd0)) : 5'd0;

  always_comb begin
    acc = '0;
    for (int j = 0; j < 3; j++)
      acc = acc + ACC_W'(RECON[base + 5'(j)] * lms2_q[j]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int i = 0; i < 3; i++)
        lms3_q[i] <= (dichro && (miss == 2'(i))) ? LMS_W'(acc >>> F) : lms2_q[i];
      gray3_q <= gray2_q;
    end
  end

  assign lms_o  = lms3_q;
  assign gray_o = gray3_q;

endmodule

### rtl/dcs_back.sv
module dcs_back (
  input  logic           clk_i,
  input  logic [2:0]     en_i,
  input  logic [2:0]     mode_i,
  input  dcs_pkg::lms_t  lms_i [3],
  input  logic [7:0]     gray_i,
  output logic [7:0]     red_o,
  output logic [7:0]     green_o,
  output logic [7:0]     blue_o
);
  import dcs_pkg::*;

  acc_t       acc [3];
  rgb_t       rgb4_q [3];
  logic [7:0] gray4_q;
  rgb_t       rgb5_q [3];
  logic [7:0] hi5_q [3];
  logic [7:0] gray5_q;
  logic [7:0] out_q [3];
  logic [7:0] hi_v [3];
  logic [7:0] lo_v [3];

  // LMS back to linear RGB
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = '0;
      for (int j = 0; j < 3; j++)
        acc[i] = acc[i] + ACC_W'(BACK_Q[3*i+j] * lms_i[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < 3; i++) rgb4_q[i] <= RGB_W'(acc[i] >>> F);
      gray4_q <= gray_i;
    end
  end

  // Gamma search, upper four bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hi_v[i] = '0;
      for (int b = 7; b >= 4; b--) begin
        if ($signed({1'b0, ((i == 1) ? THR20[hi_v[i] | 8'(1 << b)]
                                     : THR21[hi_v[i] | 8'(1 << b)])}) <= rgb4_q[i])
          hi_v[i] = hi_v[i] | 8'(1 << b);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      rgb5_q  <= rgb4_q;
      hi5_q   <= hi_v;
      gray5_q <= gray4_q;
    end
  end

  // Gamma search, lower four bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo_v[i] = hi5_q[i];
      for (int b = 3; b >= 0; b--) begin
        if ($signed({1'b0, ((i == 1) ? THR20[lo_v[i] | 8'(1 << b)]
                                     : THR21[lo_v[i] | 8'(1 << b)])}) <= rgb5_q[i])
          lo_v[i] = lo_v[i] | 8'(1 << b);
      end
    end
  end

  // Output register, grayscale bypass
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      for (int i = 0; i < 3; i++)
        out_q[i] <= (mode_i == MODE_GRAY) ? gray5_q : lo_v[i];
    end
  end

  assign red_o   = out_q[0];
  assign green_o = out_q[1];
  assign blue_o  = out_q[2];

endmodule

### rtl/dichromat_color_simulation.sv
// Throughput: one pixel per cycle while m_axis_tready does not stall the output;
// seven register stages (table lookup, LMS matrix, plane test, rebuild, RGB matrix,
// two gamma search halves) each stall locally.
// Reset: asynchronous active low, clears stage valid bits and sets the mode register
// mode_q to normal; no clearing pass, items are accepted right after reset.
`include "dichromat_color_simulation_macros.svh"

module dichromat_color_simulation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i
);
  import dcs_pkg::*;

  logic [2:0]    mode_q;
  logic [NS-1:0] vld_q;
  logic [NS-1:0] vld_d;
  logic [NS-1:0] en;
  lms_t          lms_a [3];
  lms_t          lms_b [3];
  logic [7:0]    gray_a;
  logic [7:0]    gray_b;
  logic [7:0]    red_out;
  logic [7:0]    green_out;
  logic [7:0]    blue_out;

  // Hold the mode register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    en[NS-1] = !vld_q[NS-1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) en[k] = !vld_q[k] || en[k+1];
    vld_d[0] = en[0] ? s_axis_tvalid : vld_q[0];
    for (int k = 1; k < NS; k++) vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[NS-1];

  dcs_fwd u_fwd (
    .clk_i   (clk_i),
    .en_i    (en[1:0]),
    .red_i   (s_axis_tdata[7:0]),
    .green_i (s_axis_tdata[15:8]),
    .blue_i  (s_axis_tdata[23:16]),
    .lms_o   (lms_a),
    .gray_o  (gray_a)
  );

  dcs_rebuild u_rebuild (
    .clk_i  (clk_i),
    .en_i   (en[3:2]),
    .mode_i (mode_q),
    .lms_i  (lms_a),
    .gray_i (gray_a),
    .lms_o  (lms_b),
    .gray_o (gray_b)
  );

  dcs_back u_back (
    .clk_i   (clk_i),
    .en_i    (en[6:4]),
    .mode_i  (mode_q),
    .lms_i   (lms_b),
    .gray_i  (gray_b),
    .red_o   (red_out),
    .green_o (green_out),
    .blue_o  (blue_out)
  );

  assign m_axis_tdata = {blue_out, green_out, red_out};

  `DCS_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, vld_q[0], "accepted item not in first stage")
  `DCS_ASSERT_NOW(a_full_blocks, clk_i, rst_ni, (&vld_q) && !m_axis_tready, !s_axis_tready, "input ready while pipeline full and stalled")
  `DCS_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, vld_q[3] && !en[3], vld_q[3], "stalled stage lost its item")

endmodule
